@@ design/pte_pkg.sv @@
// Package for the partition table engine: words, entry layout, codes and
// the command and status groups between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package pte_pkg;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_CREATE = 3'd3;
    localparam logic [2:0] OP_COUNT  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_INUSE    = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [24:0] DISK_RESET = 25'd2097152;
    localparam logic [32:0] START_MAX  = 33'h0FFFFFF;
    localparam logic [7:0]  COUNT_MAX  = 8'hFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  slot_index;
        logic        entry_valid;
        logic [6:0]  part_id;
        logic [23:0] start_block;
        logic [31:0] size_blocks;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] found_start;
        logic [31:0] found_size;
        logic [6:0]  result_slot;
        logic [7:0]  valid_count;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [6:0]  id;
        logic [23:0] start;
        logic [31:0] size;
    } t_entry;

    typedef struct packed {
        logic cap;
        logic rd_en;
        logic clr_wr;
        logic gap_eval;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       hit;
        logic       best_ok;
        logic       fits;
        logic       out_free;
    } t_stat;

endpackage

@@ design/pte_ctrl.sv @@
// Controller of the partition table engine: sequences clearing, table scans,
// gap passes and result delivery. Depends on pte_pkg.
`timescale 1ns / 1ps
module pte_ctrl #(
    parameter int ENTRIES = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pte_pkg::t_stat             i_stat,
    output pte_pkg::t_cmd              o_cmd,
    output logic [$clog2(ENTRIES)-1:0] o_addr
);
    localparam int AW = $clog2(ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_SCAN, S_DRAIN, S_GSCAN, S_GDRAIN, S_GEVAL, S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_stall, n_stall;
    pte_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        cmd     = '0;
        case (r_state)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                    n_addr = '0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_addr = '0;
                if (i_stat.op == pte_pkg::OP_LOOKUP || i_stat.op == pte_pkg::OP_DELETE ||
                    i_stat.op == pte_pkg::OP_CREATE || i_stat.op == pte_pkg::OP_COUNT) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_addr = '0;
                if (i_stat.op == pte_pkg::OP_CREATE && !i_stat.hit) begin
                    n_state = S_GSCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_GSCAN: begin
                cmd.rd_en = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_GDRAIN;
                end
            end
            S_GDRAIN: begin
                n_state = S_GEVAL;
            end
            S_GEVAL: begin
                cmd.gap_eval = 1'b1;
                n_addr = '0;
                // An extent whose leading gap is too small sends us to the next one.
                if (i_stat.best_ok && !i_stat.fits) begin
                    n_state = S_GSCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_stall <= 1'b1;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = cmd;
    assign o_addr     = r_addr;

endmodule

@@ design/pte_dpath.sv @@
// Datapath of the partition table engine: table memory, scan accumulators,
// gap evaluation, disk size register and output word register. Depends on pte_pkg.
`timescale 1ns / 1ps
module pte_dpath #(
    parameter int ENTRIES = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pte_pkg::t_in_word          i_in_word,
    input  logic                       i_cfg_we,
    input  logic [24:0]                i_cfg_wdata,
    input  pte_pkg::t_cmd              i_cmd,
    input  logic [$clog2(ENTRIES)-1:0] i_addr,
    output pte_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pte_pkg::t_out_word         o_out_word
);
    localparam int AW = $clog2(ENTRIES);

    pte_pkg::t_entry   r_mem [ENTRIES];
    pte_pkg::t_entry   r_rd_data;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    pte_pkg::t_in_word r_item;
    logic [24:0]       r_disk;

    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [23:0]       r_hit_start;
    logic [31:0]       r_hit_size;
    logic              r_free_ok;
    logic [AW-1:0]     r_free_idx;
    logic [7:0]        r_cnt;
    logic              r_del_any;

    logic              r_best_ok;
    logic [AW-1:0]     r_best_idx;
    logic [23:0]       r_best_start;
    logic [31:0]       r_best_size;
    logic              r_last_ok;
    logic [AW-1:0]     r_last_idx;
    logic [23:0]       r_last_start;
    logic [32:0]       r_left;
    logic              r_gap_found;
    logic [23:0]       r_where;

    pte_pkg::t_out_word r_out;
    logic               r_out_vld;

    logic            match, after_last, better, fits, load_ok;
    logic [24:0]     lim;
    logic [32:0]     ext_end;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    pte_pkg::t_entry wr_data;
    pte_pkg::t_out_word res;

    assign match = r_rd_data.valid && (r_rd_data.id == r_item.part_id);
    assign after_last = !r_last_ok || (r_rd_data.start > r_last_start) ||
                        (r_rd_data.start == r_last_start && r_rd_idx > r_last_idx);
    assign better = !r_best_ok || (r_rd_data.start < r_best_start);

    // The gap before the chosen extent ends at its start, capped by the disk size.
    always_comb begin
        lim = r_disk;
        if (r_best_ok && {1'b0, r_best_start} < r_disk) begin
            lim = {1'b0, r_best_start};
        end
    end
    assign fits = (r_left <= {8'b0, lim}) &&
                  (({8'b0, lim} - r_left) >= {1'b0, r_item.size_blocks}) &&
                  (r_left <= pte_pkg::START_MAX);
    assign ext_end = {9'b0, r_best_start} + {1'b0, r_best_size};
    assign load_ok = {25'b0, r_item.slot_index} < 32'(ENTRIES);

    always_comb begin
        res     = '0;
        wr_en   = 1'b0;
        wr_addr = i_addr;
        wr_data = '0;
        res.status = pte_pkg::ST_NOTFOUND;
        case (r_item.opcode)
            pte_pkg::OP_LOAD: begin
                if (load_ok) begin
                    res.status = pte_pkg::ST_OK;
                    res.result_slot = r_item.slot_index;
                end
            end
            pte_pkg::OP_LOOKUP: begin
                if (r_hit) begin
                    res.status = pte_pkg::ST_OK;
                    res.found_start = r_hit_start;
                    res.found_size = r_hit_size;
                    res.result_slot = 7'(r_hit_idx);
                end
            end
            pte_pkg::OP_DELETE: begin
                if (r_del_any) begin
                    res.status = pte_pkg::ST_OK;
                end
            end
            pte_pkg::OP_CREATE: begin
                if (r_hit) begin
                    res.status = pte_pkg::ST_INUSE;
                end else if (!r_gap_found) begin
                    res.status = pte_pkg::ST_NOSPACE;
                end else if (!r_free_ok) begin
                    res.status = pte_pkg::ST_FULL;
                end else begin
                    res.status = pte_pkg::ST_OK;
                    res.found_start = r_where;
                    res.found_size = r_item.size_blocks;
                    res.result_slot = 7'(r_free_idx);
                end
            end
            pte_pkg::OP_COUNT: begin
                res.status = pte_pkg::ST_OK;
                res.valid_count = r_cnt;
            end
            default: begin
                res.status = pte_pkg::ST_NOTFOUND;
            end
        endcase

        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (r_rd_vld && match && r_item.opcode == pte_pkg::OP_DELETE) begin
            wr_en = 1'b1;
            wr_addr = r_rd_idx;
            wr_data = r_rd_data;
            wr_data.valid = 1'b0;
        end else if (i_cmd.fin && r_item.opcode == pte_pkg::OP_LOAD && load_ok) begin
            wr_en = 1'b1;
            wr_addr = AW'(r_item.slot_index);
            wr_data.valid = r_item.entry_valid;
            wr_data.id = r_item.part_id;
            wr_data.start = r_item.start_block;
            wr_data.size = r_item.size_blocks;
        end else if (i_cmd.fin && r_item.opcode == pte_pkg::OP_CREATE &&
                     res.status == pte_pkg::ST_OK) begin
            wr_en = 1'b1;
            wr_addr = r_free_idx;
            wr_data.valid = 1'b1;
            wr_data.id = r_item.part_id;
            wr_data.start = r_where;
            wr_data.size = r_item.size_blocks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[i_addr];
        r_rd_idx  <= i_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_disk    <= pte_pkg::DISK_RESET;
            r_out_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_del_any <= 1'b0;
            r_best_ok <= 1'b0;
            r_last_ok <= 1'b0;
            r_gap_found <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cfg_we) begin
                r_disk <= i_cfg_wdata;
            end
            if (i_cmd.cap) begin
                r_item      <= i_in_word;
                r_hit       <= 1'b0;
                r_free_ok   <= 1'b0;
                r_cnt       <= '0;
                r_del_any   <= 1'b0;
                r_best_ok   <= 1'b0;
                r_last_ok   <= 1'b0;
                r_left      <= '0;
                r_gap_found <= 1'b0;
                r_where     <= '0;
            end else if (r_rd_vld) begin
                if (match && !r_hit) begin
                    r_hit       <= 1'b1;
                    r_hit_idx   <= r_rd_idx;
                    r_hit_start <= r_rd_data.start;
                    r_hit_size  <= r_rd_data.size;
                end
                if (match) begin
                    r_del_any <= 1'b1;
                end
                if (!r_rd_data.valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
                if (r_rd_data.valid && r_cnt != pte_pkg::COUNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                // Next extent in (start, slot) order after the one last visited.
                if (r_rd_data.valid && after_last && better) begin
                    r_best_ok    <= 1'b1;
                    r_best_idx   <= r_rd_idx;
                    r_best_start <= r_rd_data.start;
                    r_best_size  <= r_rd_data.size;
                end
            end else if (i_cmd.gap_eval) begin
                r_best_ok <= 1'b0;
                if (fits) begin
                    r_gap_found <= 1'b1;
                    r_where     <= r_left[23:0];
                end else if (r_best_ok) begin
                    if (ext_end > r_left) begin
                        r_left <= ext_end;
                    end
                    r_last_ok    <= 1'b1;
                    r_last_idx   <= r_best_idx;
                    r_last_start <= r_best_start;
                end
            end
            if (i_cmd.fin) begin
                r_out     <= res;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.op       = r_item.opcode;
    assign o_stat.hit      = r_hit;
    assign o_stat.best_ok  = r_best_ok;
    assign o_stat.fits     = fits;
    assign o_stat.out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_out_word      = r_out;

endmodule

@@ design/partition_table_engine.sv @@
// Load needs no table scan; lookup, delete and count make one pass over the table;
// create adds a pass for each gap tried, one more than the extents passed over.
// One word at a time; input stays stalled until the last result is registered.
// Reset: synchronous, active low; then a clearing pass over every entry during
// which input stays stalled. Disk size resets to 2097152 blocks.
`timescale 1ns / 1ps
module partition_table_engine #(
    parameter int ENTRIES = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pte_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pte_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic [24:0]        i_cfg_wdata
);
    pte_pkg::t_cmd                cmd;
    pte_pkg::t_stat               stat;
    logic [$clog2(ENTRIES)-1:0]   addr;

    pte_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    pte_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall) else $error("input taken during clearing pass");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall) else $error("second word taken");
    a_fin_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> stat.out_free) else $error("result overwrote pending word");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for partition_table_engine: a queue-fed driver, a monitor and
// a predictor of the partition table that expects each result word. Depends on pte_pkg.
`timescale 1ns / 1ps
module tb_top;

    localparam int SLOTS = 128;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    pte_pkg::t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    pte_pkg::t_out_word o_out_word;
    logic      i_cfg_we = 1'b0;
    logic [24:0] i_cfg_wdata = '0;

    partition_table_engine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted state of the partition table and the disk size register.
    bit          part_valid [SLOTS];
    logic [6:0]  part_id    [SLOTS];
    logic [23:0] part_start [SLOTS];
    logic [31:0] part_size  [SLOTS];
    logic [24:0] disk_limit = pte_pkg::DISK_RESET;

    pte_pkg::t_in_word  queued_commands[$];
    pte_pkg::t_out_word predicted_replies[$];
    int  mismatch_count = 0;
    int  send_idle_pct = 18;
    int  recv_idle_pct = 52;
    bit  hold_sender = 1'b0;

    function automatic int first_slot_with_id(logic [6:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (part_valid[i] && part_id[i] == id) return i;
        return -1;
    endfunction

    function automatic bit gap_holds(longint unsigned left, longint unsigned lim,
                                     longint unsigned need);
        return left <= lim && lim - left >= need && left <= 64'hFFFFFF;
    endfunction

    // First-fit sweep over valid extents in start order, ties broken by slot.
    function automatic bit first_fit(longint unsigned need, output longint unsigned where);
        longint unsigned left, last_start, s, e, lim;
        int last_slot, best;
        left = 0;
        last_start = 0;
        last_slot = -1;
        where = 0;
        forever begin
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!part_valid[i]) continue;
                s = part_start[i];
                if (last_slot >= 0 && (s < last_start || (s == last_start && i <= last_slot)))
                    continue;
                if (best < 0 || s < part_start[best]) best = i;
            end
            if (best < 0) break;
            s = part_start[best];
            e = s + part_size[best];
            lim = (s < disk_limit) ? s : disk_limit;
            if (gap_holds(left, lim, need)) begin
                where = left;
                return 1'b1;
            end
            if (e > left) left = e;
            last_start = s;
            last_slot = best;
        end
        if (gap_holds(left, disk_limit, need)) begin
            where = left;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic pte_pkg::t_out_word apply_table_op(pte_pkg::t_in_word w);
        pte_pkg::t_out_word r;
        int hit, free_slot;
        longint unsigned where;
        r = '0;
        r.status = pte_pkg::ST_NOTFOUND;
        case (w.opcode)
            pte_pkg::OP_LOAD: begin
                part_valid[w.slot_index] = w.entry_valid;
                part_id[w.slot_index]    = w.part_id;
                part_start[w.slot_index] = w.start_block;
                part_size[w.slot_index]  = w.size_blocks;
                r.status = pte_pkg::ST_OK;
                r.result_slot = w.slot_index;
            end
            pte_pkg::OP_LOOKUP: begin
                hit = first_slot_with_id(w.part_id);
                if (hit >= 0) begin
                    r.status = pte_pkg::ST_OK;
                    r.found_start = part_start[hit];
                    r.found_size = part_size[hit];
                    r.result_slot = 7'(hit);
                end
            end
            pte_pkg::OP_DELETE: begin
                for (int i = 0; i < SLOTS; i++)
                    if (part_valid[i] && part_id[i] == w.part_id) begin
                        part_valid[i] = 1'b0;
                        r.status = pte_pkg::ST_OK;
                    end
            end
            pte_pkg::OP_CREATE: begin
                free_slot = -1;
                if (first_slot_with_id(w.part_id) >= 0) begin
                    r.status = pte_pkg::ST_INUSE;
                end else if (!first_fit(w.size_blocks, where)) begin
                    r.status = pte_pkg::ST_NOSPACE;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!part_valid[i]) free_slot = i;
                    if (free_slot < 0) begin
                        r.status = pte_pkg::ST_FULL;
                    end else begin
                        part_valid[free_slot] = 1'b1;
                        part_id[free_slot]    = w.part_id;
                        part_start[free_slot] = where[23:0];
                        part_size[free_slot]  = w.size_blocks;
                        r.status = pte_pkg::ST_OK;
                        r.found_start = where[23:0];
                        r.found_size = w.size_blocks;
                        r.result_slot = 7'(free_slot);
                    end
                end
            end
            pte_pkg::OP_COUNT: begin
                for (int i = 0; i < SLOTS; i++)
                    if (part_valid[i] && r.valid_count < pte_pkg::COUNT_MAX)
                        r.valid_count++;
                r.status = pte_pkg::ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: a word stays put while stalled; the prediction is taken on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predicted_replies.push_back(apply_table_op(i_in_word));
            if (!i_in_valid || !o_in_stall) begin
                if (queued_commands.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= queued_commands.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        pte_pkg::t_out_word want;
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_out_word), 0);
            end else begin
                want = predicted_replies.pop_front();
                if (o_out_word.status !== want.status)
                    report_mismatch("status", o_out_word.status, want.status);
                if (o_out_word.found_start !== want.found_start)
                    report_mismatch("found_start", o_out_word.found_start, want.found_start);
                if (o_out_word.found_size !== want.found_size)
                    report_mismatch("found_size", o_out_word.found_size, want.found_size);
                if (o_out_word.result_slot !== want.result_slot)
                    report_mismatch("result_slot", o_out_word.result_slot, want.result_slot);
                if (o_out_word.valid_count !== want.valid_count)
                    report_mismatch("valid_count", o_out_word.valid_count, want.valid_count);
            end
        end
    end

    task automatic send(logic [2:0] op, logic [6:0] slot, logic vld, logic [6:0] id,
                        logic [23:0] start, logic [31:0] size);
        pte_pkg::t_in_word w;
        w.opcode = op;
        w.slot_index = slot;
        w.entry_valid = vld;
        w.part_id = id;
        w.start_block = start;
        w.size_blocks = size;
        queued_commands.push_back(w);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_commands.size() > 0 || i_in_valid || predicted_replies.size() > 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_disk_blocks(logic [24:0] blocks);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= blocks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        disk_limit = blocks;
    endtask

    function automatic pte_pkg::t_in_word random_command();
        pte_pkg::t_in_word w;
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)      w.opcode = pte_pkg::OP_LOAD;
        else if (pick < 40) w.opcode = pte_pkg::OP_LOOKUP;
        else if (pick < 50) w.opcode = pte_pkg::OP_DELETE;
        else if (pick < 82) w.opcode = pte_pkg::OP_CREATE;
        else if (pick < 95) w.opcode = pte_pkg::OP_COUNT;
        else                w.opcode = 3'($urandom_range(5, 7)); // undefined opcodes
        w.slot_index = 7'($urandom);
        w.entry_valid = ($urandom_range(3) != 0);
        // A narrow id range keeps lookups, deletes and id clashes frequent.
        w.part_id = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(15));
        w.start_block = $urandom_range(1) ? 24'($urandom_range(0, 32'(disk_limit)))
                                          : 24'($urandom);
        pick = $urandom_range(9);
        if (pick == 0)      w.size_blocks = 0;
        else if (pick == 1) w.size_blocks = $urandom;
        else                w.size_blocks = $urandom_range(1, 4096);
        return w;
    endfunction

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            part_valid[i] = 1'b0;
            part_id[i] = '0;
            part_start[i] = '0;
            part_size[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, id clash, no space, field extremes, undefined opcodes.
        write_disk_blocks(25'd1000);
        send(pte_pkg::OP_COUNT, 0, 0, 0, 0, 0);
        send(pte_pkg::OP_LOOKUP, 0, 0, 0, 0, 0);
        send(pte_pkg::OP_DELETE, 0, 0, 3, 0, 0);
        send(pte_pkg::OP_CREATE, 0, 0, 1, 0, 0);
        send(pte_pkg::OP_CREATE, 0, 0, 1, 0, 5);
        send(pte_pkg::OP_CREATE, 0, 0, 2, 0, 500);
        send(pte_pkg::OP_CREATE, 0, 0, 3, 0, 600);
        send(pte_pkg::OP_LOAD, 127, 1, 127, 24'hFFFFFF, 32'hFFFFFFFF);
        send(pte_pkg::OP_LOAD, 5, 0, 9, 24'h123456, 32'h55AA55AA);
        send(pte_pkg::OP_LOOKUP, 0, 0, 127, 0, 0);
        send(pte_pkg::OP_LOOKUP, 0, 0, 9, 0, 0);
        send(3'd5, 7'h7F, 1, 7'h7F, 24'hFFFFFF, 32'hFFFFFFFF);
        send(3'd6, 0, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0, 0);
        send(pte_pkg::OP_COUNT, 0, 0, 0, 0, 0);
        send(pte_pkg::OP_DELETE, 0, 0, 1, 0, 0);
        send(pte_pkg::OP_CREATE, 0, 0, 4, 0, 32'hFFFFFFFF);
        write_disk_blocks(25'h1000000);
        send(pte_pkg::OP_CREATE, 0, 0, 6, 0, 32'h00FFFFFF);
        send(pte_pkg::OP_CREATE, 0, 0, 7, 0, 32'h01000000);
        write_disk_blocks(25'd0);
        send(pte_pkg::OP_CREATE, 0, 0, 8, 0, 1);
        send(pte_pkg::OP_CREATE, 0, 0, 10, 0, 0);

        // Fill every slot with one shared id, then hit the table-full case.
        write_disk_blocks(pte_pkg::DISK_RESET);
        for (int i = 0; i < SLOTS; i++)
            send(pte_pkg::OP_LOAD, 7'(i), 1, 100, 24'(1000 + 10 * i), 10);
        send(pte_pkg::OP_CREATE, 0, 0, 5, 0, 1);
        send(pte_pkg::OP_COUNT, 0, 0, 0, 0, 0);
        send(pte_pkg::OP_DELETE, 0, 0, 100, 0, 0);

        // The sender holds back until every outstanding word has returned.
        hold_sender = 1'b1;
        do @(negedge i_clk);
        while (i_in_valid || predicted_replies.size() > 0);
        hold_sender = 1'b0;

        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin
                send_idle_pct = 52;
                recv_idle_pct = 18;
                write_disk_blocks(25'($urandom_range(2000, 32'h1000000)));
            end else if (p == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                write_disk_blocks(25'h1000000);
            end
            for (int n = 0; n < 12; n++)
                queued_commands.push_back(random_command());
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
